// ===== rtl/stack_with_max_tracking_macros.svh =====
// Assertion macros for the max-tracking stack.
`ifndef STACK_WITH_MAX_TRACKING_MACROS_SVH
`define STACK_WITH_MAX_TRACKING_MACROS_SVH

`ifndef SYNTHESIS

// cond must hold at every clock edge outside reset
`define SMT_ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("invariant violated");

// ante in one cycle implies cons in the next
`define SMT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`else

`define SMT_ASSERT_ALWAYS(label, clk, rst_n, cond)
`define SMT_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/smt_pkg.sv =====
// Shared constants and types for the max-tracking stack.
`default_nettype none

package smt_pkg;

    localparam int STACK_DEPTH = 64;
    localparam int VALUE_WIDTH = 32;
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

    typedef enum logic {
        OP_PUSH = 1'b0,
        OP_POP  = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_UNDERFLOW = 2'd1,
        ST_OVERFLOW  = 2'd2
    } t_status;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    typedef struct packed {
        logic                          opcode;
        logic signed [VALUE_WIDTH-1:0] push_value;
    } t_in_item;

    typedef struct packed {
        logic signed [VALUE_WIDTH-1:0] popped_value;
        logic signed [VALUE_WIDTH-1:0] max_value;
        logic                          is_empty;
        logic [CNT_W-1:0]              depth_now;
        t_status                       status;
    } t_out_item;

    // one entry of the maximum stack
    typedef struct packed {
        logic signed [VALUE_WIDTH-1:0] value;
        logic [CNT_W-1:0]              count;
    } t_max_pair;

    // write-back and pointer update from the execute logic
    typedef struct packed {
        logic                   elem_we;
        logic [ADDR_W-1:0]      elem_waddr;
        logic [VALUE_WIDTH-1:0] elem_wdata;
        logic                   max_we;
        logic [ADDR_W-1:0]      max_waddr;
        t_max_pair              max_wdata;
        logic [CNT_W-1:0]       elem_top;
        logic [CNT_W-1:0]       max_top;
    } t_upd;

endpackage

`default_nettype wire

// ===== rtl/smt_elem_mem.sv =====
// Element memory: one write port, one registered read port.
`default_nettype none

module smt_elem_mem (
    input  wire logic                           i_clk,
    input  wire logic                           i_we,
    input  wire logic [smt_pkg::ADDR_W-1:0]     i_waddr,
    input  wire logic [smt_pkg::VALUE_WIDTH-1:0] i_wdata,
    input  wire logic                           i_re,
    input  wire logic [smt_pkg::ADDR_W-1:0]     i_raddr,
    output logic      [smt_pkg::VALUE_WIDTH-1:0] o_rdata
);
    import smt_pkg::*;

    logic [VALUE_WIDTH-1:0] r_mem [STACK_DEPTH];
    logic [VALUE_WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== rtl/smt_max_mem.sv =====
// Maximum-pair memory: one write port, two registered read ports (top and below top).
`default_nettype none

module smt_max_mem (
    input  wire logic                       i_clk,
    input  wire logic                       i_we,
    input  wire logic [smt_pkg::ADDR_W-1:0] i_waddr,
    input  wire smt_pkg::t_max_pair         i_wdata,
    input  wire logic                       i_re,
    input  wire logic [smt_pkg::ADDR_W-1:0] i_raddr_top,
    input  wire logic [smt_pkg::ADDR_W-1:0] i_raddr_below,
    output smt_pkg::t_max_pair              o_rdata_top,
    output smt_pkg::t_max_pair              o_rdata_below
);
    import smt_pkg::*;

    t_max_pair r_mem [STACK_DEPTH];
    t_max_pair r_rdata_top;
    t_max_pair r_rdata_below;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata_top   <= r_mem[i_raddr_top];
            r_rdata_below <= r_mem[i_raddr_below];
        end
    end

    assign o_rdata_top   = r_rdata_top;
    assign o_rdata_below = r_rdata_below;

endmodule

`default_nettype wire

// ===== rtl/smt_exec.sv =====
// Execute logic: read-modify-write decision and result for one push or pop.
`default_nettype none

module smt_exec (
    input  wire smt_pkg::t_in_item          i_item,
    input  wire logic [smt_pkg::CNT_W-1:0]  i_elem_top,
    input  wire logic [smt_pkg::CNT_W-1:0]  i_max_top,
    input  wire logic [smt_pkg::VALUE_WIDTH-1:0] i_elem_rd,
    input  wire smt_pkg::t_max_pair         i_max_rd_top,
    input  wire smt_pkg::t_max_pair         i_max_rd_below,
    output smt_pkg::t_upd                   o_upd,
    output smt_pkg::t_out_item              o_result
);
    import smt_pkg::*;

    logic                          w_full;
    logic                          w_empty;
    logic                          w_has_max;
    logic signed [VALUE_WIDTH-1:0] w_x;
    logic signed [VALUE_WIDTH-1:0] w_m;
    logic [CNT_W-1:0]              w_cnt;
    logic [CNT_W-1:0]              w_max_dec;
    logic signed [VALUE_WIDTH-1:0] w_max_cand;

    assign w_full    = (i_elem_top == CNT_W'(STACK_DEPTH));
    assign w_empty   = (i_elem_top == '0);
    assign w_has_max = (i_max_top != '0);
    assign w_x       = i_item.push_value;
    assign w_m       = i_max_rd_top.value;
    assign w_cnt     = i_max_rd_top.count;
    assign w_max_dec = i_max_top - CNT_W'(1);

    always_comb begin
        o_upd              = '0;
        o_upd.elem_top     = i_elem_top;
        o_upd.max_top      = i_max_top;
        o_result           = '0;
        o_result.status    = ST_OK;
        w_max_cand         = w_m;

        if (i_item.opcode == OP_PUSH) begin
            if (w_full) begin
                o_result.status = ST_OVERFLOW;
            end else begin
                o_upd.elem_we    = 1'b1;
                o_upd.elem_waddr = i_elem_top[ADDR_W-1:0];
                o_upd.elem_wdata = w_x;
                o_upd.elem_top   = i_elem_top + CNT_W'(1);
                if (!w_has_max) begin
                    // first element: open the maximum stack
                    o_upd.max_we          = 1'b1;
                    o_upd.max_waddr       = '0;
                    o_upd.max_wdata.value = w_x;
                    o_upd.max_wdata.count = CNT_W'(1);
                    o_upd.max_top         = CNT_W'(1);
                    w_max_cand            = w_x;
                end else if (w_x == w_m) begin
                    o_upd.max_we          = 1'b1;
                    o_upd.max_waddr       = w_max_dec[ADDR_W-1:0];
                    o_upd.max_wdata.value = w_m;
                    o_upd.max_wdata.count = w_cnt + CNT_W'(1);
                end else if (w_x > w_m && i_max_top < CNT_W'(STACK_DEPTH)) begin
                    // new, larger maximum
                    o_upd.max_we          = 1'b1;
                    o_upd.max_waddr       = i_max_top[ADDR_W-1:0];
                    o_upd.max_wdata.value = w_x;
                    o_upd.max_wdata.count = CNT_W'(1);
                    o_upd.max_top         = i_max_top + CNT_W'(1);
                    w_max_cand            = w_x;
                end
            end
        end else begin
            if (w_empty) begin
                o_result.status = ST_UNDERFLOW;
            end else begin
                o_upd.elem_top        = i_elem_top - CNT_W'(1);
                o_result.popped_value = i_elem_rd;
                if (w_has_max && i_elem_rd == w_m) begin
                    if (w_cnt <= CNT_W'(1)) begin
                        // last copy of the maximum leaves: fall back to the pair below
                        o_upd.max_top = w_max_dec;
                        w_max_cand    = i_max_rd_below.value;
                    end else begin
                        o_upd.max_we          = 1'b1;
                        o_upd.max_waddr       = w_max_dec[ADDR_W-1:0];
                        o_upd.max_wdata.value = w_m;
                        o_upd.max_wdata.count = w_cnt - CNT_W'(1);
                    end
                end
            end
        end

        o_result.is_empty  = (o_upd.elem_top == '0);
        o_result.depth_now = o_upd.elem_top;
        o_result.max_value = (o_upd.elem_top == '0) ? '0 : w_max_cand;
    end

endmodule

`default_nettype wire

// ===== rtl/stack_with_max_tracking.sv =====
// Top level of the max-tracking stack: sequencer, pointers, memories and output register.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+--------------------------
//  input   | in        | i_in_valid / o_in_ready    | i_in_item  (t_in_item)
//  output  | out       | o_out_valid / i_out_ready  | o_out_item (t_out_item)
//
// Steps: an item is accepted while both memories read its operands, then it is
//   executed and written back; both memories have registered read ports.
// Reset: clears the pointers, the sequencer and the output valid; memory
//   contents are left as they are (entries above the top may be read but are never used).
// Stalls: while the output register still holds an untaken item, execute
//   waits; the input is taken again once the write back has completed.
`default_nettype none
`include "stack_with_max_tracking_macros.svh"

module stack_with_max_tracking (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire smt_pkg::t_in_item  i_in_item,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output smt_pkg::t_out_item      o_out_item
);
    import smt_pkg::*;

    // sequencer
    t_state r_state;
    t_state n_state;

    // stack pointers: count of held elements and of held maximum pairs
    logic [CNT_W-1:0] r_elem_top;
    logic [CNT_W-1:0] r_max_top;

    // item under work
    t_in_item r_item;

    // output register
    logic      r_out_valid;
    t_out_item r_out_item;

    logic w_in_accept;
    logic w_done;

    logic [CNT_W-1:0] w_elem_dec;
    logic [CNT_W-1:0] w_max_dec1;
    logic [CNT_W-1:0] w_max_dec2;

    logic [VALUE_WIDTH-1:0] w_elem_rd;
    t_max_pair              w_max_rd_top;
    t_max_pair              w_max_rd_below;
    t_upd                   w_upd;
    t_out_item              w_result;

    // terms for the checks at the end
    logic               w_empty_res_ok;
    logic [2*CNT_W-1:0] w_tops;

    assign o_in_ready  = (r_state == S_IDLE);
    assign w_in_accept = i_in_valid && o_in_ready;
    // execute completes once the output register has room
    assign w_done      = (r_state == S_EXEC) && (!r_out_valid || i_out_ready);

    // read addresses: top entry of each stack, and the pair below the top maximum
    assign w_elem_dec = r_elem_top - CNT_W'(1);
    assign w_max_dec1 = r_max_top - CNT_W'(1);
    assign w_max_dec2 = r_max_top - CNT_W'(2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (w_done) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // pointers move only at write back
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_elem_top <= '0;
            r_max_top  <= '0;
        end else if (w_done) begin
            r_elem_top <= w_upd.elem_top;
            r_max_top  <= w_upd.max_top;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_item <= i_in_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_done) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_done) begin
            r_out_item <= w_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    smt_elem_mem u_elem_mem (
        .i_clk   (i_clk),
        .i_we    (w_done && w_upd.elem_we),
        .i_waddr (w_upd.elem_waddr),
        .i_wdata (w_upd.elem_wdata),
        .i_re    (w_in_accept),
        .i_raddr (w_elem_dec[ADDR_W-1:0]),
        .o_rdata (w_elem_rd)
    );

    smt_max_mem u_max_mem (
        .i_clk         (i_clk),
        .i_we          (w_done && w_upd.max_we),
        .i_waddr       (w_upd.max_waddr),
        .i_wdata       (w_upd.max_wdata),
        .i_re          (w_in_accept),
        .i_raddr_top   (w_max_dec1[ADDR_W-1:0]),
        .i_raddr_below (w_max_dec2[ADDR_W-1:0]),
        .o_rdata_top   (w_max_rd_top),
        .o_rdata_below (w_max_rd_below)
    );

    smt_exec u_exec (
        .i_item         (r_item),
        .i_elem_top     (r_elem_top),
        .i_max_top      (r_max_top),
        .i_elem_rd      (w_elem_rd),
        .i_max_rd_top   (w_max_rd_top),
        .i_max_rd_below (w_max_rd_below),
        .o_upd          (w_upd),
        .o_result       (w_result)
    );

    assign w_empty_res_ok = !(o_out_valid && o_out_item.is_empty)
                            || (o_out_item.max_value == '0 && o_out_item.depth_now == '0);
    assign w_tops         = {r_elem_top, r_max_top};

    // every held maximum pair covers at least one held element
    `SMT_ASSERT_ALWAYS(a_max_le_elem, i_clk, i_rst_n, r_max_top <= r_elem_top)
    // element count never exceeds the capacity
    `SMT_ASSERT_ALWAYS(a_elem_cap, i_clk, i_rst_n, r_elem_top <= CNT_W'(STACK_DEPTH))
    // an empty result reports zero maximum and zero depth
    `SMT_ASSERT_ALWAYS(a_empty_res, i_clk, i_rst_n, w_empty_res_ok)
    // pointers stay put while no item is in execute
    `SMT_ASSERT_NEXT(a_idle_hold, i_clk, i_rst_n, r_state == S_IDLE, $stable(w_tops))

endmodule

`default_nettype wire
